// ===== src/bes_pkg.sv =====
// Shared constants and the sequencer state type for the exclusive scan block.
// No dependencies; imported by bes_mem and blelloch_exclusive_scan.
package bes_pkg;

  localparam int DefMaxLogLength = 6;
  localparam int DefDataWidth    = 32;
  localparam int ValueW          = 32;
  localparam int PrefixW         = 32;
  localparam int CfgW            = 3;
  localparam logic [CfgW-1:0] CfgLogReset = 3'd6;

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_UP_RD  = 9'b000000010,
    ST_UP_WR  = 9'b000000100,
    ST_CLEAR  = 9'b000001000,
    ST_DN_RD  = 9'b000010000,
    ST_DN_WL  = 9'b000100000,
    ST_DN_WR  = 9'b001000000,
    ST_EM_RD  = 9'b010000000,
    ST_EM_CAP = 9'b100000000
  } bes_state_e;

endpackage

// ===== src/bes_mem.sv =====
// Block store: one write port, two read ports, read data registered.
// Depends on bes_pkg for default widths.
module bes_mem import bes_pkg::*; #(
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int ADDR_W     = DefMaxLogLength
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_a_i,
  input  logic [ADDR_W-1:0]     raddr_b_i,
  output logic [DATA_WIDTH-1:0] rdata_a_o,
  output logic [DATA_WIDTH-1:0] rdata_b_o
);

  localparam int Depth = 1 << ADDR_W;

  logic [DATA_WIDTH-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== src/blelloch_exclusive_scan.sv =====
// Channel  Dir  Fields (tdata low bit up)        Accepted when
// s_axis   in   tdata[31:0] value                 s_axis_tvalid_i & s_axis_tready_o
// m_axis   out  tdata[31:0] prefix, tlast = last  m_axis_tvalid_o & m_axis_tready_i
// cfg      in   cfg_wdata_i[2:0] log_length       cfg_we_i
// A block of N = 2^log_length words (log_length capped at MAX_LOG_LENGTH) is loaded, then
// swept up (read, write per pair), cleared, swept down (read, write left, write right per pair)
// and emitted (read, capture per result), paced by the single write port of the block store.
// Reset is asynchronous, active low; the store holds no reset value and needs no sweep.
// Input is taken only while loading; a stalled result holds the emit sequence.
module blelloch_exclusive_scan import bes_pkg::*; #(
  parameter int MAX_LOG_LENGTH = DefMaxLogLength,
  parameter int DATA_WIDTH     = DefDataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,     // log_length
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ValueW-1:0]  s_axis_tdata_i,  // [31:0] value
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [PrefixW-1:0] m_axis_tdata_o,  // [31:0] prefix
  output logic               m_axis_tlast_o   // last
);

  localparam int AW   = MAX_LOG_LENGTH;
  localparam int LgW  = $clog2(MAX_LOG_LENGTH + 1);
  localparam int ExtW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  bes_state_e state_q, state_d;
  logic [CfgW-1:0]  cfg_log_q;
  logic [AW:0]      load_cnt_q, load_cnt_d;
  logic [LgW-1:0]   lvl_q, lvl_d;
  logic [AW-1:0]    base_q, base_d;
  logic             out_vld_q;
  logic [PrefixW-1:0] out_data_q;
  logic             out_last_q;

  logic [LgW-1:0]   lg_eff;
  logic [AW:0]      n_full, half_m1, span_m1, span;
  logic [AW-1:0]    last_addr, l_addr, r_addr;
  logic             in_acc, out_load, pair_done;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_ra, mem_rb;
  logic [DATA_WIDTH-1:0] mem_wdata, rd_a, rd_b;
  logic [ExtW-1:0]       in_ext, out_ext;

  assign lg_eff    = (int'(cfg_log_q) > MAX_LOG_LENGTH) ? LgW'(MAX_LOG_LENGTH)
                                                        : LgW'(cfg_log_q);
  assign n_full    = (AW+1)'(1) << lg_eff;
  assign last_addr = AW'(n_full - 1'b1);
  assign half_m1   = ((AW+1)'(1) << lvl_q) - 1'b1;
  assign span      = (AW+1)'(2) << lvl_q;
  assign span_m1   = span - 1'b1;
  assign l_addr    = AW'(base_q + half_m1);
  assign r_addr    = AW'(base_q + span_m1);
  assign pair_done = (r_addr == last_addr);

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == ST_EM_CAP) && (!out_vld_q || m_axis_tready_i);

  assign in_ext  = ExtW'(s_axis_tdata_i);
  assign out_ext = ExtW'(rd_a);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_cnt_q[AW-1:0];
    mem_wdata = in_ext[DATA_WIDTH-1:0];
    mem_re    = 1'b0;
    mem_ra    = l_addr;
    mem_rb    = r_addr;
    unique case (state_q)
      ST_LOAD: begin
        mem_we = in_acc;
      end
      ST_UP_RD, ST_DN_RD: begin
        mem_re = 1'b1;
      end
      ST_UP_WR, ST_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = r_addr;
        mem_wdata = rd_a + rd_b;
      end
      ST_DN_WL: begin
        mem_we    = 1'b1;
        mem_waddr = l_addr;
        mem_wdata = rd_b;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = last_addr;
        mem_wdata = '0;
      end
      ST_EM_RD: begin
        mem_re = 1'b1;
        mem_ra = base_q;
      end
      ST_EM_CAP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    lvl_d      = lvl_q;
    base_d     = base_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if ((load_cnt_q + 1'b1) == n_full) begin
            load_cnt_d = '0;
            lvl_d      = '0;
            base_d     = '0;
            state_d    = (lg_eff == '0) ? ST_CLEAR : ST_UP_RD;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_UP_RD: state_d = ST_UP_WR;
      ST_UP_WR: begin
        if (!pair_done) begin
          base_d  = AW'(base_q + span);
          state_d = ST_UP_RD;
        end else if (LgW'(lvl_q + 1'b1) == lg_eff) begin
          state_d = ST_CLEAR;
        end else begin
          lvl_d   = lvl_q + 1'b1;
          base_d  = '0;
          state_d = ST_UP_RD;
        end
      end
      ST_CLEAR: begin
        base_d = '0;
        if (lg_eff == '0) begin
          state_d = ST_EM_RD;
        end else begin
          lvl_d   = lg_eff - 1'b1;
          state_d = ST_DN_RD;
        end
      end
      ST_DN_RD: state_d = ST_DN_WL;
      ST_DN_WL: state_d = ST_DN_WR;
      ST_DN_WR: begin
        if (!pair_done) begin
          base_d  = AW'(base_q + span);
          state_d = ST_DN_RD;
        end else if (lvl_q == '0) begin
          base_d  = '0;
          state_d = ST_EM_RD;
        end else begin
          lvl_d   = lvl_q - 1'b1;
          base_d  = '0;
          state_d = ST_DN_RD;
        end
      end
      ST_EM_RD: state_d = ST_EM_CAP;
      ST_EM_CAP: begin
        if (out_load) begin
          if (base_q == last_addr) begin
            state_d = ST_LOAD;
          end else begin
            base_d  = base_q + 1'b1;
            state_d = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
    if (cfg_we_i) begin
      load_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cfg_log_q  <= CfgLogReset;
      load_cnt_q <= '0;
      lvl_q      <= '0;
      base_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      lvl_q      <= lvl_d;
      base_q     <= base_d;
      if (cfg_we_i) begin
        cfg_log_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_ext[PrefixW-1:0];
      out_last_q <= (base_q == last_addr);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  bes_mem #(
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_ra),
    .raddr_b_i (mem_rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

`ifndef SYNTHESIS
  a_cap_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM_CAP) |-> $past(state_q == ST_EM_RD || state_q == ST_EM_CAP))
    else $error("emit capture without a preceding read");

  a_load_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (load_cnt_q < n_full))
    else $error("load count reached block length");

  a_last_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (base_q == last_addr)) |=> (state_q == ST_LOAD && m_axis_tlast_o))
    else $error("final result did not end the block");
`endif

endmodule
